// ----- hw/rtl/stc_pkg.sv -----
// Shared constants and types for the stick-to-cursor mover.
`default_nettype none

package stc_pkg;

  // Default screen geometry in pixels
  localparam int unsigned DefScreenWidth  = 320;
  localparam int unsigned DefScreenHeight = 240;

  // Field and register widths
  localparam int unsigned StickW = 16;  // Q2.14 stick sample
  localparam int unsigned SensW  = 12;  // Q4.8 sensitivity
  localparam int unsigned FracW  = 24;  // signed Q10.14 sub-pixel accumulator
  localparam int unsigned FracFb = 14;  // fraction bits of the accumulator
  localparam int unsigned MagW   = 16;  // axis magnitude, up to 32768
  localparam int unsigned ProdW  = 28;  // magnitude times sensitivity
  localparam int unsigned VelW   = 18;  // velocity magnitude, up to 262080
  localparam int unsigned StepW  = 6;   // whole-pixel step, -16 to 16

  // Deadzone: 0.05 in Q2.14, axis counts only above it
  localparam logic [MagW-1:0] Deadzone = 16'd819;
  // 1.0 squared in Q4.28
  localparam logic [31:0] OneSq = 32'h1000_0000;

  localparam logic [SensW-1:0] SensReset = 12'd256;

  // Configuration register indexes
  localparam int unsigned CfgAddrW = 1;
  localparam logic [CfgAddrW-1:0] RegEnable = 1'b0;
  localparam logic [CfgAddrW-1:0] RegSens   = 1'b1;

endpackage

`default_nettype wire

// ----- hw/rtl/stick_to_cursor_mover.sv -----
// Stick-to-cursor mover: deadzone, magnitude normalise, sub-pixel accumulate, clamp.
//
// Slave stream s_axis carries one stick sample per transaction; master stream
// m_axis returns one cursor transaction for every sample taken. Write enable
// and sensitivity through cfg_we_i/cfg_addr_i/cfg_wdata_i only while the block
// is idle; a write takes effect at once.
// Sequence: a disabled sample goes straight to S_DONE; otherwise S_PREP,
// S_SQX, S_SQY, S_SUM, S_PX, S_PY, S_ACC, S_MOVE, S_DONE, with S_SQRT,
// S_DIVX and S_DIVY between S_PY and S_ACC when the magnitude is above 1.0.
// s_axis_tready is high only in S_IDLE, which follows the output load. The
// long case is set by one shared 33-bit subtractor: digit-by-digit square
// root, then restoring division for each axis. One 16x16 multiplier forms
// both squares and both scaled magnitudes, one product per cycle.
// Reset: cursor to mid-screen, accumulators and touch latch clear, block
// disabled, sensitivity 1.0. No clearing pass is needed.
// Stalls: a result waiting on m_axis_tready does not block acceptance of the
// next sample; that sample is held in its final state until the output
// register is free, which delays it by the length of the stall.
`default_nettype none

module stick_to_cursor_mover #(
  parameter int unsigned SCREEN_WIDTH  = stc_pkg::DefScreenWidth,
  parameter int unsigned SCREEN_HEIGHT = stc_pkg::DefScreenHeight
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // stick_x [15:0], stick_y [31:16], touch [32], zero pad to 40 bits
  input  wire logic [39:0]                   s_axis_tdata,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // cursor_col [COL_W-1:0], cursor_row next ROW_W bits, touching above,
  // zero pad to whole bytes
  output logic [((($clog2(SCREEN_WIDTH) + $clog2(SCREEN_HEIGHT) + 1) + 7) / 8) * 8 - 1:0]
                                             m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  input  wire logic                          cfg_we_i,
  input  wire logic [stc_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [stc_pkg::SensW-1:0]     cfg_wdata_i
);

  import stc_pkg::*;

  localparam int unsigned COL_W = $clog2(SCREEN_WIDTH);
  localparam int unsigned ROW_W = $clog2(SCREEN_HEIGHT);
  localparam int unsigned PW    = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int unsigned SUM_W = PW + StepW;
  localparam int unsigned OUT_W = (((COL_W + ROW_W + 1) + 7) / 8) * 8;

  localparam logic signed [SUM_W-1:0] ColMax = SUM_W'(SCREEN_WIDTH - 1);
  localparam logic signed [SUM_W-1:0] RowMax = SUM_W'(SCREEN_HEIGHT - 1);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0_0000_0000_0001,
    S_PREP = 13'b0_0000_0000_0010,
    S_SQX  = 13'b0_0000_0000_0100,
    S_SQY  = 13'b0_0000_0000_1000,
    S_SUM  = 13'b0_0000_0001_0000,
    S_PX   = 13'b0_0000_0010_0000,
    S_PY   = 13'b0_0000_0100_0000,
    S_SQRT = 13'b0_0000_1000_0000,
    S_DIVX = 13'b0_0001_0000_0000,
    S_DIVY = 13'b0_0010_0000_0000,
    S_ACC  = 13'b0_0100_0000_0000,
    S_MOVE = 13'b0_1000_0000_0000,
    S_DONE = 13'b1_0000_0000_0000
  } state_e;

  // Configuration
  logic             en_q;
  logic [SensW-1:0] sens_q;

  // Sequencer and datapath registers
  state_e state_q, state_d;
  logic signed [StickW:0] px_q, px_d, py_q, py_d;
  logic                   tin_q, tin_d;
  logic [MagW-1:0]        ax_q, ax_d, ay_q, ay_d;
  logic                   sx_q, sx_d, sy_q, sy_d;
  logic [31:0]            prod_q, prod_d;
  logic [31:0]            m2_q, m2_d;
  logic [ProdW-1:0]       pa_q, pa_d, pb_q, pb_d;
  logic [31:0]            n_q, n_d, root_q, root_d, bit_q, bit_d;
  logic [MagW-1:0]        rem_q, rem_d;
  logic [VelW-1:0]        dsh_q, dsh_d;
  logic [4:0]             cnt_q, cnt_d;
  logic [VelW-1:0]        qx_q, qx_d, qy_q, qy_d;
  logic                   vzero_q, vzero_d;

  // Cursor state
  logic [COL_W-1:0]        pos_col_q, pos_col_d;
  logic [ROW_W-1:0]        pos_row_q, pos_row_d;
  logic signed [FracW-1:0] frac_col_q, frac_col_d, frac_row_q, frac_row_d;
  logic                    touch_q, touch_d;

  // Output register
  logic             out_valid_q, out_valid_d;
  logic [COL_W-1:0] out_col_q, out_col_d;
  logic [ROW_W-1:0] out_row_q, out_row_d;
  logic             out_touch_q, out_touch_d;

  // Shared units
  logic [MagW-1:0] mul_a, mul_b;
  logic [31:0]     mul_p;
  logic [32:0]     sub_a, sub_b, sub_diff;
  logic            sub_ge;
  logic [MagW:0]   div_r;

  logic signed [FracW-1:0] dx_col_full, dx_row_full;
  logic signed [StepW-1:0] dx_col, dx_row;
  logic signed [SUM_W-1:0] sum_col, sum_row;

  assign mul_p    = mul_a * mul_b;
  assign sub_diff = sub_a - sub_b;
  assign sub_ge   = ~sub_diff[32];
  assign div_r    = {rem_q, dsh_q[VelW-1]};

  // Whole-pixel step, truncated toward zero
  assign dx_col_full = (frac_col_q >>> FracFb)
                     + FracW'(frac_col_q[FracW-1] && (frac_col_q[FracFb-1:0] != '0));
  assign dx_row_full = (frac_row_q >>> FracFb)
                     + FracW'(frac_row_q[FracW-1] && (frac_row_q[FracFb-1:0] != '0));
  assign dx_col = dx_col_full[StepW-1:0];
  assign dx_row = dx_row_full[StepW-1:0];
  assign sum_col = $signed(SUM_W'(pos_col_q)) + SUM_W'(dx_col);
  assign sum_row = $signed(SUM_W'(pos_row_q)) + SUM_W'(dx_row);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_touch_q, out_row_q, out_col_q});

  // Shared operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    sub_a = '0;
    sub_b = '0;
    unique case (state_q)
      S_SQX: begin
        mul_a = ax_q;
        mul_b = ax_q;
      end
      S_SQY: begin
        mul_a = ay_q;
        mul_b = ay_q;
      end
      S_SUM: begin
        mul_a = ax_q;
        mul_b = MagW'(sens_q);
      end
      S_PX: begin
        mul_a = ay_q;
        mul_b = MagW'(sens_q);
      end
      S_SQRT: begin
        sub_a = {1'b0, n_q};
        sub_b = {1'b0, root_q | bit_q};
      end
      S_DIVX, S_DIVY: begin
        sub_a = 33'(div_r);
        sub_b = 33'(root_q[MagW-1:0]);
      end
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    px_d        = px_q;
    py_d        = py_q;
    tin_d       = tin_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    prod_d      = prod_q;
    m2_d        = m2_q;
    pa_d        = pa_q;
    pb_d        = pb_q;
    n_d         = n_q;
    root_d      = root_q;
    bit_d       = bit_q;
    rem_d       = rem_q;
    dsh_d       = dsh_q;
    cnt_d       = cnt_q;
    qx_d        = qx_q;
    qy_d        = qy_q;
    vzero_d     = vzero_q;
    pos_col_d   = pos_col_q;
    pos_row_d   = pos_row_q;
    frac_col_d  = frac_col_q;
    frac_row_d  = frac_row_q;
    touch_d     = touch_q;
    out_valid_d = out_valid_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    out_touch_d = out_touch_q;

    // Drop the result once taken
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          px_d  = $signed({s_axis_tdata[15], s_axis_tdata[15:0]});
          py_d  = -$signed({s_axis_tdata[31], s_axis_tdata[31:16]});
          tin_d = s_axis_tdata[32];
          state_d = en_q ? S_PREP : S_DONE;
        end
      end
      S_PREP: begin
        // Magnitude and sign per axis, inside the deadzone counts as zero
        ax_d = px_q[StickW] ? MagW'(-px_q) : px_q[MagW-1:0];
        ay_d = py_q[StickW] ? MagW'(-py_q) : py_q[MagW-1:0];
        if (ax_d <= Deadzone) ax_d = '0;
        if (ay_d <= Deadzone) ay_d = '0;
        sx_d = px_q[StickW];
        sy_d = py_q[StickW];
        state_d = S_SQX;
      end
      S_SQX: begin
        prod_d  = mul_p;
        state_d = S_SQY;
      end
      S_SQY: begin
        m2_d    = prod_q;
        prod_d  = mul_p;
        state_d = S_SUM;
      end
      S_SUM: begin
        m2_d    = m2_q + prod_q;
        prod_d  = mul_p;
        state_d = S_PX;
      end
      S_PX: begin
        pa_d    = prod_q[ProdW-1:0];
        prod_d  = mul_p;
        state_d = S_PY;
      end
      S_PY: begin
        pb_d = prod_q[ProdW-1:0];
        if (m2_q <= OneSq) begin
          qx_d    = pa_q[VelW+7:8];
          qy_d    = prod_q[VelW+7:8];
          state_d = S_ACC;
        end else begin
          n_d     = m2_q;
          root_d  = '0;
          bit_d   = 32'h4000_0000;
          cnt_d   = 5'd15;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        // One result bit per cycle
        if (sub_ge) begin
          n_d    = sub_diff[31:0];
          root_d = (root_q >> 1) | bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          rem_d   = pa_q[ProdW-1:ProdW-MagW];
          dsh_d   = {pa_q[ProdW-MagW-1:0], 6'b0};
          cnt_d   = 5'(VelW - 1);
          state_d = S_DIVX;
        end
      end
      S_DIVX, S_DIVY: begin
        // Shift in one numerator bit, subtract the root where it fits
        rem_d = sub_ge ? sub_diff[MagW-1:0] : div_r[MagW-1:0];
        dsh_d = {dsh_q[VelW-2:0], sub_ge};
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          if (state_q == S_DIVX) begin
            qx_d    = dsh_d;
            rem_d   = pb_q[ProdW-1:ProdW-MagW];
            dsh_d   = {pb_q[ProdW-MagW-1:0], 6'b0};
            cnt_d   = 5'(VelW - 1);
            state_d = S_DIVY;
          end else begin
            qy_d    = dsh_d;
            state_d = S_ACC;
          end
        end
      end
      S_ACC: begin
        frac_col_d = frac_col_q + (sx_q ? -FracW'(qx_q) : FracW'(qx_q));
        frac_row_d = frac_row_q + (sy_q ? -FracW'(qy_q) : FracW'(qy_q));
        vzero_d    = (qx_q == '0) && (qy_q == '0);
        state_d    = S_MOVE;
      end
      S_MOVE: begin
        // Clamp the cursor; subtract the full step, or clear the accumulators at zero velocity
        if (sum_col[SUM_W-1])      pos_col_d = '0;
        else if (sum_col > ColMax) pos_col_d = ColMax[COL_W-1:0];
        else                       pos_col_d = sum_col[COL_W-1:0];
        if (sum_row[SUM_W-1])      pos_row_d = '0;
        else if (sum_row > RowMax) pos_row_d = RowMax[ROW_W-1:0];
        else                       pos_row_d = sum_row[ROW_W-1:0];
        if (vzero_q) begin
          frac_col_d = '0;
          frac_row_d = '0;
        end else begin
          frac_col_d = frac_col_q - ({{(FracW-StepW){dx_col[StepW-1]}}, dx_col} << FracFb);
          frac_row_d = frac_row_q - ({{(FracW-StepW){dx_row[StepW-1]}}, dx_row} << FracFb);
        end
        touch_d = tin_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_col_d   = pos_col_q;
          out_row_d   = pos_row_q;
          out_touch_d = touch_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b0;
      sens_q <= SensReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegEnable: en_q   <= cfg_wdata_i[0];
        RegSens:   sens_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Control and cursor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_col_q   <= COL_W'(SCREEN_WIDTH / 2);
      pos_row_q   <= ROW_W'(SCREEN_HEIGHT / 2);
      frac_col_q  <= '0;
      frac_row_q  <= '0;
      touch_q     <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      pos_col_q   <= pos_col_d;
      pos_row_q   <= pos_row_d;
      frac_col_q  <= frac_col_d;
      frac_row_q  <= frac_row_d;
      touch_q     <= touch_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Datapath payload
  always_ff @(posedge clk_i) begin
    px_q        <= px_d;
    py_q        <= py_d;
    tin_q       <= tin_d;
    ax_q        <= ax_d;
    ay_q        <= ay_d;
    sx_q        <= sx_d;
    sy_q        <= sy_d;
    prod_q      <= prod_d;
    m2_q        <= m2_d;
    pa_q        <= pa_d;
    pb_q        <= pb_d;
    n_q         <= n_d;
    root_q      <= root_d;
    bit_q       <= bit_d;
    rem_q       <= rem_d;
    dsh_q       <= dsh_d;
    qx_q        <= qx_d;
    qy_q        <= qy_d;
    vzero_q     <= vzero_d;
    out_col_q   <= out_col_d;
    out_row_q   <= out_row_d;
    out_touch_q <= out_touch_d;
  end

  // Cursor stays on screen
  a_pos_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(pos_col_q) < SCREEN_WIDTH) && (32'(pos_row_q) < SCREEN_HEIGHT))
    else $error("cursor left the screen");

  // Accumulators hold less than one pixel after a move
  a_frac_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |->
      (frac_col_q > -24'sd16384) && (frac_col_q < 24'sd16384) &&
      (frac_row_q > -24'sd16384) && (frac_row_q < 24'sd16384))
    else $error("accumulator not settled after move");

  // Normalised velocity never exceeds the full-push speed
  a_vel_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |->
      (qx_q <= {sens_q, 6'b0}) && (qy_q <= {sens_q, 6'b0}))
    else $error("velocity above sensitivity bound");

endmodule

`default_nettype wire

// ----- tb/sv/tb_stick_to_cursor_mover.sv -----
// Self-checking testbench for the stick-to-cursor mover with cursor prediction and scoreboard.
`default_nettype none

module tb_stick_to_cursor_mover;

  // Screen geometry and stream widths, matched to the instance below
  localparam int ScreenW    = int'(stc_pkg::DefScreenWidth);
  localparam int ScreenH    = int'(stc_pkg::DefScreenHeight);
  localparam int ColW       = $clog2(ScreenW);
  localparam int RowW       = $clog2(ScreenH);
  localparam int OutW       = ((ColW + RowW + 1 + 7) / 8) * 8;
  localparam int PixelOne   = 1 << stc_pkg::FracFb;      // one pixel in Q.14
  localparam int DeadBand   = int'(stc_pkg::Deadzone);
  localparam int SettleWait = 70;                        // longer than the worst-case latency
  localparam int CycleLimit = 1_000_000;

  logic                         clk_i;
  logic                         rst_ni;
  // stick_x [15:0], stick_y [31:16], touch [32], zero pad to 40 bits
  logic [39:0]                  s_axis_tdata;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  // cursor_col [8:0], cursor_row [16:9], touching [17], zero pad to 24 bits
  logic [OutW-1:0]              m_axis_tdata;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic                         cfg_we_i;
  logic [stc_pkg::CfgAddrW-1:0] cfg_addr_i;
  logic [stc_pkg::SensW-1:0]    cfg_wdata_i;

  stick_to_cursor_mover #(
    .SCREEN_WIDTH (ScreenW),
    .SCREEN_HEIGHT(ScreenH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Cursor predictor and queue of expected cursor transactions
  class cursor_scoreboard;
    typedef struct packed {
      logic            touching;
      logic [RowW-1:0] row;
      logic [ColW-1:0] col;
    } cursor_t;

    bit                        enable;
    logic [stc_pkg::SensW-1:0] sens;
    int                        col_pos;
    int                        row_pos;
    int                        col_frac;
    int                        row_frac;
    bit                        touch_held;
    cursor_t                   expected_cursor_q[$];
    int                        errors;

    function new();
      enable     = 1'b0;
      sens       = stc_pkg::SensReset;
      col_pos    = ScreenW / 2;
      row_pos    = ScreenH / 2;
      col_frac   = 0;
      row_frac   = 0;
      touch_held = 1'b0;
      errors     = 0;
    endfunction

    // Only the low register bits matter; enable keeps bit 0
    function void write_reg(logic [stc_pkg::CfgAddrW-1:0] idx, logic [stc_pkg::SensW-1:0] val);
      if (idx == stc_pkg::RegEnable) begin
        enable = val[0];
      end else begin
        sens = val;
      end
    endfunction

    // Floor square root by setting bits from the top down
    function longint unsigned floor_root(longint unsigned n);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 15; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= n) r = t;
      end
      return r;
    endfunction

    // Scaled velocity of one axis in Q.14, magnitude truncated then signed
    function int axis_velocity(int p, longint unsigned m2);
      longint unsigned mag;
      longint unsigned q;
      mag = (p < 0) ? longint'(-p) : longint'(p);
      if (m2 <= longint'(stc_pkg::OneSq)) begin
        q = (mag * sens) >> 8;
      end else begin
        q = (mag * sens * 64) / floor_root(m2);
      end
      return (p < 0) ? -int'(q) : int'(q);
    endfunction

    function int clamp_pos(int v, int top);
      if (v < 0) return 0;
      if (v > top) return top;
      return v;
    endfunction

    function void note_sample(logic [39:0] d);
      int              px;
      int              py;
      int              vx;
      int              vy;
      int              dx;
      int              dy;
      longint unsigned m2;
      cursor_t         want;
      if (enable) begin
        px = int'($signed(d[15:0]));
        py = -int'($signed(d[31:16]));
        if ((px < 0 ? -px : px) <= DeadBand) px = 0;
        if ((py < 0 ? -py : py) <= DeadBand) py = 0;
        m2 = longint'(px * px) + longint'(py * py);
        vx = axis_velocity(px, m2);
        vy = axis_velocity(py, m2);
        col_frac += vx;
        row_frac += vy;
        dx = col_frac / PixelOne;
        dy = row_frac / PixelOne;
        if (dx != 0 || dy != 0) begin
          col_pos  = clamp_pos(col_pos + dx, ScreenW - 1);
          row_pos  = clamp_pos(row_pos + dy, ScreenH - 1);
          col_frac -= dx * PixelOne;
          row_frac -= dy * PixelOne;
        end
        if (vx == 0 && vy == 0) begin
          col_frac = 0;
          row_frac = 0;
        end
        touch_held = d[32];
      end
      want.col      = col_pos[ColW-1:0];
      want.row      = row_pos[RowW-1:0];
      want.touching = touch_held;
      expected_cursor_q.push_back(want);
    endfunction

    function void check_cursor(logic [OutW-1:0] d);
      cursor_t want;
      if (expected_cursor_q.size() == 0) begin
        $error("cursor transaction %h with nothing expected", d);
        errors++;
        return;
      end
      want = expected_cursor_q.pop_front();
      if (d[ColW-1:0] != want.col) begin
        $error("cursor_col: expected %0d, actual %0d", want.col, d[ColW-1:0]);
        errors++;
      end
      if (d[ColW+RowW-1:ColW] != want.row) begin
        $error("cursor_row: expected %0d, actual %0d", want.row, d[ColW+RowW-1:ColW]);
        errors++;
      end
      if (d[ColW+RowW] != want.touching) begin
        $error("touching: expected %0d, actual %0d", want.touching, d[ColW+RowW]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_cursor_q.size();
    endfunction
  endclass

  cursor_scoreboard sb = new();

  int burst_left;
  int ready_mode;
  int mode_left;
  int cycle_count;

  // Clock: 12 time units per period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: end the run if the block stops answering
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Monitor both streams at the rising edge; check before noting so that a
  // result can never be matched against the sample taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_cursor(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata);
    end
  end

  // Receiver back-pressure: switch between always ready, coin-toss and
  // mostly stalled, each held for a random stretch of cycles
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(20, 200);
    end
    mode_left--;
    case (ready_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        m_axis_tready <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  // Present one sample and hold it until the block takes it; tvalid stays
  // high afterwards unless pace() ends a burst, so back-to-back transactions need no extra assignment
  task automatic send_item(int x, int y, bit touch);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, touch, y[15:0], x[15:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    pace();
  endtask

  // Sender bursts: after each burst drop tvalid for a random gap, or none
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  // Hold off the sender until every cursor has come back and the block is idle
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [stc_pkg::CfgAddrW-1:0] idx, logic [stc_pkg::SensW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic int clip16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int pick_direction();
    case ($urandom_range(0, 6))
      0:       return -32768;
      1:       return -16384;
      2:       return -9000;
      3:       return 0;
      4:       return 9000;
      5:       return 16384;
      default: return 32767;
    endcase
  endfunction

  // One loose sample: full range, deadzone border, centred or inside the unit circle
  task automatic random_sample();
    int x;
    int y;
    case ($urandom_range(0, 5))
      0, 1: begin
        x = int'($urandom_range(0, 65535)) - 32768;
        y = int'($urandom_range(0, 65535)) - 32768;
      end
      2: begin
        x = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(700, 950));
        y = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(700, 950));
      end
      3: begin
        x = int'($urandom_range(0, 2 * DeadBand)) - DeadBand;
        y = int'($urandom_range(0, 2 * DeadBand)) - DeadBand;
      end
      default: begin
        x = int'($urandom_range(0, 22000)) - 11000;
        y = int'($urandom_range(0, 22000)) - 11000;
      end
    endcase
    send_item(x, y, 1'($urandom_range(0, 1)));
  endtask

  // Sustained push in one direction with jitter: drives the cursor into edges
  task automatic send_run(int n);
    int bx;
    int by;
    bx = pick_direction();
    by = pick_direction();
    for (int i = 0; i < n; i++) begin
      send_item(clip16(bx + int'($urandom_range(0, 1000)) - 500),
                clip16(by + int'($urandom_range(0, 1000)) - 500),
                1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_phase(int n);
    int left;
    int len;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 2) == 0) begin
        len = $urandom_range(4, 30);
        if (len > left) len = left;
        send_run(len);
        left -= len;
      end else begin
        random_sample();
        left--;
      end
    end
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = stc_pkg::RegEnable;
    cfg_wdata_i   = '0;
    burst_left    = 0;
    ready_mode    = 0;
    mode_left     = 0;
    cycle_count   = 0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Disabled after reset: the cursor must report mid-screen, no touch
    send_item(16384, 0, 1'b1);
    send_item(-32768, 32767, 1'b1);
    settle();
    write_reg(stc_pkg::RegEnable, 12'd1);

    // Unit sensitivity: centred, deadzone border, both extremes, exactly full
    // push, just inside the unit circle, slow fractional creep
    send_item(0, 0, 1'b0);
    send_item(819, -819, 1'b1);
    send_item(820, 0, 1'b1);
    send_item(-820, 0, 1'b0);
    send_item(0, 820, 1'b1);
    send_item(0, -32768, 1'b0);
    send_item(32767, 32767, 1'b1);
    send_item(-32768, -32768, 1'b0);
    send_item(16384, 0, 1'b1);
    send_item(11585, 11585, 1'b0);
    send_item(1000, -1000, 1'b1);
    send_item(1000, -1000, 1'b1);
    send_item(0, 0, 1'b0);

    // Top sensitivity: drive into the top-right corner and keep pushing
    settle();
    write_reg(stc_pkg::RegSens, 12'd4095);
    for (int i = 0; i < 14; i++) send_item(32767, 32767, 1'b1);
    run_phase(200);

    // Zero sensitivity: every update has zero velocity
    settle();
    write_reg(stc_pkg::RegSens, 12'd0);
    run_phase(60);

    // Smallest sensitivity: tiny velocities, many truncate to zero
    settle();
    write_reg(stc_pkg::RegSens, 12'd1);
    run_phase(150);

    // Disable through an oversized write whose low bit is clear
    settle();
    write_reg(stc_pkg::RegEnable, 12'hFFE);
    run_phase(60);
    settle();
    write_reg(stc_pkg::RegEnable, 12'h801);

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      write_reg(stc_pkg::RegSens, 12'($urandom_range(2, 4094)));
      run_phase(150);
    end

    settle();
    if (sb.pending() == 0 && sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
hw/rtl/stc_pkg.sv
hw/rtl/stick_to_cursor_mover.sv
tb/sv/tb_stick_to_cursor_mover.sv
